@@ sv/multi_waveform_lfo_top_defines.svh @@
// Assertion macros shared by the oscillator RTL.
`ifndef MULTI_WAVEFORM_LFO_TOP_DEFINES_SVH
`define MULTI_WAVEFORM_LFO_TOP_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define MWLFO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that holds in the cycle after its condition.
`define MWLFO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mwlfo_pkg.sv @@
// Types and constants of the multi-waveform low frequency oscillator.
package mwlfo_pkg;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int CNT_W = $clog2(MUL_B_W);

	typedef logic signed [MUL_P_W-1:0] prod_t;
	typedef logic signed [31:0] word_t;
	typedef logic signed [15:0] sample_t;

	localparam logic [16:0] SIN_A = 17'd51472;
	localparam logic [16:0] SIN_B = 17'd21024;
	localparam logic [24:0] SIN_C = 25'd2320;
	localparam logic signed [15:0] CLIP_LEVEL = 16'sd6554;
	localparam logic [24:0] SCALE_NINE_TENTHS = 25'd29491;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [2:0] MODE_SINE = 3'd0;
	localparam logic [2:0] MODE_TRI = 3'd1;
	localparam logic [2:0] MODE_SAW = 3'd2;
	localparam logic [2:0] MODE_SQUARE = 3'd3;

	localparam logic [2:0] CFG_PHASE_STEP = 3'd0;
	localparam logic [2:0] CFG_WAVE_MODE = 3'd1;
	localparam logic [2:0] CFG_B0 = 3'd2;
	localparam logic [2:0] CFG_B1 = 3'd3;
	localparam logic [2:0] CFG_B2 = 3'd4;
	localparam logic [2:0] CFG_A1 = 3'd5;
	localparam logic [2:0] CFG_A2 = 3'd6;

	localparam logic [31:0] RST_PHASE_STEP = 32'd48697;
	localparam logic signed [23:0] RST_B0 = 24'sd15790;
	localparam logic signed [23:0] RST_B1 = 24'sd31581;
	localparam logic signed [23:0] RST_B2 = 24'sd15790;
	localparam logic signed [23:0] RST_A1 = -24'sd7629860;
	localparam logic signed [23:0] RST_A2 = 24'sd3498720;

endpackage

@@ sv/multi_waveform_lfo_top.sv @@
// Multi-waveform low frequency oscillator with a bit-serial shared multiplier.
//
// Channel  Direction  Transaction
// s_axis   in         one command: tick one sample or write one table entry
// m_axis   out        one Q1.15 sample per tick
// cfg      in         one register write, index and data
//
// A tick holds the block until its sample is in the output register: every product goes
// through one shift-add multiplier that retires one multiplier bit a cycle.
// A table write leaves the block idle, ready for the next command. After reset a clearing
// pass zeroes every table entry while no command is taken; register writes are taken.
// A finished sample waits in the output register while the next command is taken.
`include "multi_waveform_lfo_top_defines.svh"

module multi_waveform_lfo_top #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // entry_index [9:0], entry_value [25:10], zero
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // wave_sample
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = mwlfo_pkg::MUL_P_W + 1;
	localparam int BW = mwlfo_pkg::MUL_B_W;
	localparam int AWM = mwlfo_pkg::MUL_A_W;
	localparam logic [33:0] POS_LIMIT = 34'(TABLE_DEPTH) << 20;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
	localparam logic [BW-1:0] DEPTH_B = BW'(TABLE_DEPTH);
	localparam logic signed [39:0] MAX32 = 40'sd2147483647;
	localparam logic signed [39:0] MIN32 = -40'sd2147483648;
	localparam logic signed [39:0] MAX16 = 40'sd32767;
	localparam logic signed [39:0] MIN16 = -40'sd32768;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_MUL,
		ST_SIN_PREP, ST_SIN_X2, ST_SIN_T1, ST_SIN_T2, ST_SIN_Y,
		ST_TRI,
		ST_TBL_POS, ST_TBL_RA, ST_TBL_RB, ST_TBL_RC, ST_TBL_I1, ST_TBL_I2,
		ST_BQ0, ST_BQ1, ST_BQ2, ST_BQ3, ST_BQ4, ST_BQ5,
		ST_TBL_END, ST_OUT
	} state_t;

	function automatic mwlfo_pkg::word_t sat32(input logic signed [39:0] v);
		if (v > MAX32) begin
			return 32'sh7FFFFFFF;
		end else if (v < MIN32) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic mwlfo_pkg::sample_t sat16(input logic signed [39:0] v);
		if (v > MAX16) begin
			return 16'sh7FFF;
		end else if (v < MIN16) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	state_t state_q, ret_q, iss_ret;

	logic [31:0] phase_step_q;
	logic [2:0]  mode_q;
	logic signed [23:0] b0_q, b1_q, b2_q, a1_q, a2_q;

	logic [31:0] sin_ph_q, sq_ph_q, tri_q, ph_w_q, pos_q;
	mwlfo_pkg::word_t saw_q, s1_q, s2_q, fx_q, fo_q;
	logic        neg_q, is_sq_q, is_tbl_q;
	logic [15:0] x_q, x2_q;
	mwlfo_pkg::prod_t prod_q;
	mwlfo_pkg::sample_t tv0_q, tv1_q, res_q;
	logic [AW-1:0] idx_q, clr_q, nxt_idx;
	logic [19:0] frac_q;
	logic [15:0] m_tdata_q;
	logic        m_tvalid_q;

	logic signed [AWM-1:0] mul_a_q, iss_a;
	logic [BW-1:0] mul_b_q, iss_b;
	logic [PW-1:0] mul_p_q, mul_p_next;
	logic [mwlfo_pkg::CNT_W-1:0] mul_cnt_q;
	logic mul_last, iss_go;
	logic signed [AWM:0] mul_addend, mul_hi;
	mwlfo_pkg::prod_t mul_prod;

	logic in_acc, tick_acc, wr_in_range;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0] ram_wdata, ram_rdata;

	logic [31:0] sin_new, sq_new, tri_new;
	logic [15:0] sx;
	logic [16:0] t1, t2;
	mwlfo_pkg::sample_t sine_s, clip_s, y_res, tri_res, saw_res, tbl_res;
	logic signed [39:0] y_ext;
	logic [31:0] tri_abs;
	logic signed [33:0] saw_sum, saw_adj;
	mwlfo_pkg::word_t saw_in, bq_out, bq_s1, bq_s2, interp;
	logic signed [PW-1:0] p_diff, p_sum;
	logic [32:0] tbl_inc;
	logic [33:0] pos_sum, pos_new;

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign in_acc = s_tvalid && s_tready;
	assign tick_acc = in_acc && (s_tuser == mwlfo_pkg::CMD_TICK);
	assign wr_in_range = 32'(s_tdata[9:0]) < 32'(TABLE_DEPTH);

	assign ram_we = (state_q == ST_CLEAR)
		|| (in_acc && (s_tuser == mwlfo_pkg::CMD_WRITE) && wr_in_range);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(s_tdata[9:0]);
	assign ram_wdata = (state_q == ST_CLEAR) ? 16'd0 : s_tdata[25:10];
	assign nxt_idx = (idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);
	assign ram_raddr = (state_q == ST_TBL_RB) ? nxt_idx : idx_q;

	mwlfo_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign mul_last = (mul_cnt_q == mwlfo_pkg::CNT_W'(BW - 1));
	assign mul_prod = mul_p_q[mwlfo_pkg::MUL_P_W-1:0];

	always_comb begin
		if (!mul_b_q[0]) begin
			mul_addend = '0;
		end else if (mul_last) begin
			mul_addend = -(AWM + 1)'(mul_a_q);
		end else begin
			mul_addend = (AWM + 1)'(mul_a_q);
		end
		mul_hi = $signed(mul_p_q[PW-1:BW]) + mul_addend;
		mul_p_next = $signed({mul_hi, mul_p_q[BW-1:0]}) >>> 1;
	end

	always_comb begin
		sin_new = sin_ph_q + phase_step_q;
		sq_new = sq_ph_q + phase_step_q;
		tri_new = tri_q + phase_step_q;
		sx = ph_w_q[30] ? (16'h8000 - {1'b0, ph_w_q[29:15]}) : {1'b0, ph_w_q[29:15]};
		t1 = mwlfo_pkg::SIN_B - mul_prod[31:15];
		t2 = mwlfo_pkg::SIN_A - mul_prod[31:15];

		y_ext = 40'($signed({1'b0, mul_prod[31:15]}));
		if (neg_q) begin
			y_ext = -y_ext;
		end
		sine_s = sat16(y_ext);
		if (sine_s > mwlfo_pkg::CLIP_LEVEL) begin
			clip_s = mwlfo_pkg::CLIP_LEVEL;
		end else if (sine_s < -mwlfo_pkg::CLIP_LEVEL) begin
			clip_s = -mwlfo_pkg::CLIP_LEVEL;
		end else begin
			clip_s = sine_s;
		end
		y_res = is_sq_q ? sat16((40'(clip_s) <<< 2) + 40'(clip_s)) : sine_s;

		tri_abs = tri_q[31] ? (~tri_q + 32'd1) : tri_q;
		tri_res = sat16($signed({23'd0, tri_abs[31:15]}) - 40'sd32768);

		saw_sum = 34'(saw_q) + $signed({3'd0, phase_step_q[31:1]});
		saw_adj = (saw_sum >= 34'sd1073741824) ? saw_sum - 34'sd2147483648 : saw_sum;
		saw_in = sat32(40'(saw_adj));

		bq_out = sat32(40'(mul_prod >>> 22) + 40'(s1_q));
		p_diff = PW'(prod_q) - PW'(mul_prod);
		p_sum = PW'(prod_q) + PW'(mul_prod);
		bq_s1 = sat32(40'(p_diff >>> 22) + 40'(s2_q));
		bq_s2 = sat32(40'(p_diff >>> 22));
		interp = sat32(40'(p_sum >>> 5));
		saw_res = sat16(40'(fo_q >>> 15));
		tbl_res = sat16(40'(mul_prod >>> 30));

		tbl_inc = mul_prod[44:12];
		pos_sum = {2'b0, pos_q} + {1'b0, tbl_inc};
		pos_new = (pos_sum >= POS_LIMIT) ? '0 : pos_sum;
	end

	always_comb begin
		iss_go = 1'b0;
		iss_a = '0;
		iss_b = '0;
		iss_ret = ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_acc && (mode_q != mwlfo_pkg::MODE_SINE) && (mode_q != mwlfo_pkg::MODE_TRI)
						&& (mode_q != mwlfo_pkg::MODE_SAW) && (mode_q != mwlfo_pkg::MODE_SQUARE)) begin
					iss_go = 1'b1;
					iss_a = $signed({1'b0, phase_step_q});
					iss_b = DEPTH_B;
					iss_ret = ST_TBL_POS;
				end
			end
			ST_SIN_PREP: begin
				iss_go = 1'b1;
				iss_a = AWM'(sx);
				iss_b = BW'(sx);
				iss_ret = ST_SIN_X2;
			end
			ST_SIN_X2: begin
				iss_go = 1'b1;
				iss_a = AWM'(mul_prod[30:15]);
				iss_b = mwlfo_pkg::SIN_C;
				iss_ret = ST_SIN_T1;
			end
			ST_SIN_T1: begin
				iss_go = 1'b1;
				iss_a = AWM'(x2_q);
				iss_b = BW'(t1);
				iss_ret = ST_SIN_T2;
			end
			ST_SIN_T2: begin
				iss_go = 1'b1;
				iss_a = AWM'(x_q);
				iss_b = BW'(t2);
				iss_ret = ST_SIN_Y;
			end
			ST_TBL_RC: begin
				iss_go = 1'b1;
				iss_a = AWM'(21'h100000 - {1'b0, frac_q});
				iss_b = BW'(tv0_q);
				iss_ret = ST_TBL_I1;
			end
			ST_TBL_I1: begin
				iss_go = 1'b1;
				iss_a = AWM'(frac_q);
				iss_b = BW'(tv1_q);
				iss_ret = ST_TBL_I2;
			end
			ST_BQ0: begin
				iss_go = 1'b1;
				iss_a = AWM'(fx_q);
				iss_b = BW'(b0_q);
				iss_ret = ST_BQ1;
			end
			ST_BQ1: begin
				iss_go = 1'b1;
				iss_a = AWM'(fx_q);
				iss_b = BW'(b1_q);
				iss_ret = ST_BQ2;
			end
			ST_BQ2: begin
				iss_go = 1'b1;
				iss_a = AWM'(fo_q);
				iss_b = BW'(a1_q);
				iss_ret = ST_BQ3;
			end
			ST_BQ3: begin
				iss_go = 1'b1;
				iss_a = AWM'(fx_q);
				iss_b = BW'(b2_q);
				iss_ret = ST_BQ4;
			end
			ST_BQ4: begin
				iss_go = 1'b1;
				iss_a = AWM'(fo_q);
				iss_b = BW'(a2_q);
				iss_ret = ST_BQ5;
			end
			ST_BQ5: begin
				if (is_tbl_q) begin
					iss_go = 1'b1;
					iss_a = AWM'(fo_q);
					iss_b = mwlfo_pkg::SCALE_NINE_TENTHS;
					iss_ret = ST_TBL_END;
				end
			end
			default: begin
				iss_go = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q <= ST_IDLE;
			clr_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			phase_step_q <= mwlfo_pkg::RST_PHASE_STEP;
			mode_q <= mwlfo_pkg::MODE_SINE;
			b0_q <= mwlfo_pkg::RST_B0;
			b1_q <= mwlfo_pkg::RST_B1;
			b2_q <= mwlfo_pkg::RST_B2;
			a1_q <= mwlfo_pkg::RST_A1;
			a2_q <= mwlfo_pkg::RST_A2;
			sin_ph_q <= '0;
			sq_ph_q <= '0;
			tri_q <= '0;
			saw_q <= '0;
			pos_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			mul_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					mwlfo_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data;
					mwlfo_pkg::CFG_WAVE_MODE: mode_q <= cfg_data[2:0];
					mwlfo_pkg::CFG_B0: b0_q <= cfg_data[23:0];
					mwlfo_pkg::CFG_B1: b1_q <= cfg_data[23:0];
					mwlfo_pkg::CFG_B2: b2_q <= cfg_data[23:0];
					mwlfo_pkg::CFG_A1: a1_q <= cfg_data[23:0];
					mwlfo_pkg::CFG_A2: a2_q <= cfg_data[23:0];
					default: begin
					end
				endcase
			end

			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (tick_acc) begin
						is_sq_q <= (mode_q == mwlfo_pkg::MODE_SQUARE);
						is_tbl_q <= 1'b1;
						unique case (mode_q)
							mwlfo_pkg::MODE_SINE: begin
								sin_ph_q <= sin_new;
								ph_w_q <= sin_new;
								state_q <= ST_SIN_PREP;
							end
							mwlfo_pkg::MODE_SQUARE: begin
								sq_ph_q <= sq_new;
								ph_w_q <= sq_new;
								state_q <= ST_SIN_PREP;
							end
							mwlfo_pkg::MODE_TRI: begin
								tri_q <= tri_new;
								state_q <= ST_TRI;
							end
							mwlfo_pkg::MODE_SAW: begin
								fx_q <= saw_in;
								is_tbl_q <= 1'b0;
								state_q <= ST_BQ0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					mul_p_q <= mul_p_next;
					mul_b_q <= mul_b_q >> 1;
					mul_cnt_q <= mul_cnt_q + mwlfo_pkg::CNT_W'(1);
					if (mul_last) begin
						state_q <= ret_q;
					end
				end
				ST_SIN_PREP: begin
					x_q <= sx;
					neg_q <= ph_w_q[31];
				end
				ST_SIN_X2: x2_q <= mul_prod[30:15];
				ST_SIN_T1, ST_SIN_T2: begin
				end
				ST_SIN_Y: begin
					res_q <= y_res;
					state_q <= ST_OUT;
				end
				ST_TRI: begin
					res_q <= tri_res;
					state_q <= ST_OUT;
				end
				ST_TBL_POS: begin
					pos_q <= pos_new[31:0];
					idx_q <= pos_new[20 +: AW];
					frac_q <= pos_new[19:0];
					state_q <= ST_TBL_RA;
				end
				ST_TBL_RA: state_q <= ST_TBL_RB;
				ST_TBL_RB: begin
					tv0_q <= ram_rdata;
					state_q <= ST_TBL_RC;
				end
				ST_TBL_RC: tv1_q <= ram_rdata;
				ST_TBL_I1: prod_q <= mul_prod;
				ST_TBL_I2: begin
					fx_q <= interp;
					state_q <= ST_BQ0;
				end
				ST_BQ0: begin
				end
				ST_BQ1: fo_q <= bq_out;
				ST_BQ2: prod_q <= mul_prod;
				ST_BQ3: s1_q <= bq_s1;
				ST_BQ4: prod_q <= mul_prod;
				ST_BQ5: begin
					s2_q <= bq_s2;
					if (!is_tbl_q) begin
						saw_q <= fo_q;
						res_q <= saw_res;
						state_q <= ST_OUT;
					end
				end
				ST_TBL_END: begin
					res_q <= tbl_res;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q <= res_q;
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (iss_go) begin
				mul_a_q <= iss_a;
				mul_b_q <= iss_b;
				mul_p_q <= '0;
				mul_cnt_q <= '0;
				ret_q <= iss_ret;
				state_q <= ST_MUL;
			end
		end
	end

	`MWLFO_ASSERT_NOW(a_no_cmd_in_clear, state_q == ST_CLEAR, !s_tready,
		"command taken during the table clearing pass")
	`MWLFO_ASSERT_NOW(a_ram_write_idle, ram_we,
		state_q == ST_CLEAR || state_q == ST_IDLE, "table written while a tick is at work")
	`MWLFO_ASSERT_NEXT(a_tick_leaves_idle, tick_acc, state_q != ST_IDLE,
		"accepted tick did not start any work")
	`MWLFO_ASSERT_NEXT(a_mul_restarts, iss_go, state_q == ST_MUL && mul_cnt_q == '0,
		"multiplication issued but not started")

endmodule

@@ sv/mwlfo_ram.sv @@
// Generic single write port RAM with registered read.
module mwlfo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
